>>> hdl/apmq_pkg.sv
// Shared types and codes for the alarm priority message queue.
package apmq_pkg;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned TOTAL_W = 5;

  // operation codes
  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RECV = 1'b1;

  // message kinds
  localparam logic KIND_NORMAL = 1'b0;
  localparam logic KIND_ALARM  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_ROOM  = 2'd1;
  localparam logic [1:0] ST_NULL_MSG = 2'd2;
  localparam logic [1:0] ST_NO_MSG   = 2'd3;

  typedef struct packed {
    logic            operation;
    logic            kind;
    logic [ID_W-1:0] msg_id;
  } apmq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               out_kind;
    logic [ID_W-1:0]    out_id;
    logic [TOTAL_W-1:0] total_count;
    logic               alarm_count;
  } apmq_out_t;

endpackage

>>> hdl/apmq_store.sv
// Normal-message storage with a registered, prefetched head-of-queue read.
module apmq_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [apmq_pkg::ID_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr_nxt,
  output logic [apmq_pkg::ID_W-1:0] head_data
);

  logic [apmq_pkg::ID_W-1:0] mem [DEPTH];
  logic [apmq_pkg::ID_W-1:0] head_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // head_r always tracks the entry at the read pointer; forward a write
  // that lands on the entry about to become the head
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr_nxt)) begin
      head_r <= wr_data;
    end else begin
      head_r <= mem[rd_addr_nxt];
    end
  end

  assign head_data = head_r;

endmodule

>>> hdl/alarm_priority_message_queue_top.sv
// Top level of the alarm priority message queue.
//
// Usage: each input transaction on in_* is a send (operation 0) or a receive
// (operation 1). A send queues msg_id as a normal message or into the single
// alarm slot; a receive returns the alarm first, then normal messages in
// arrival order. Every input transaction gives exactly one result
// transaction on out_*, carrying a status and the message and alarm counts
// held after the operation.
// Path: an accepted input transaction is held in the input register, then its
// result is captured in the result register that drives out_*. Throughput:
// one transaction per cycle while the receiver keeps out_ready high, set by
// the combinational update of pointers, counts and the alarm slot, with the
// queue head kept prefetched in a register by the store.
// Reset (rst_n low, synchronous) empties the queue and drops any transaction
// in flight; store contents are not cleared and need no sweep.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready drops only once both are occupied.
module alarm_priority_message_queue_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  apmq_pkg::apmq_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output apmq_pkg::apmq_out_t out_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = (CW + 1 > apmq_pkg::TOTAL_W) ? CW + 1 : apmq_pkg::TOTAL_W;

  // input stage
  logic               s1_valid_r;
  apmq_pkg::apmq_in_t s1_item_r;

  // result stage
  logic                out_valid_r;
  apmq_pkg::apmq_out_t out_data_r;
  apmq_pkg::apmq_out_t res;

  // queue state
  logic                      alarm_valid_r, alarm_valid_nxt;
  logic [apmq_pkg::ID_W-1:0] alarm_id_r, alarm_id_nxt;
  logic [AW-1:0]             rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]             wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;

  logic                      wr_en;
  logic [apmq_pkg::ID_W-1:0] head_data;
  logic [SW-1:0]             total_sum;

  logic out_free;
  logic s1_fire;

  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  always_comb begin
    alarm_valid_nxt = alarm_valid_r;
    alarm_id_nxt    = alarm_id_r;
    rd_ptr_nxt      = rd_ptr_r;
    wr_ptr_nxt      = wr_ptr_r;
    cnt_nxt         = cnt_r;
    wr_en           = 1'b0;
    res.status      = apmq_pkg::ST_OK;
    res.out_kind    = apmq_pkg::KIND_NORMAL;
    res.out_id      = '0;
    if (s1_fire) begin
      if (s1_item_r.operation == apmq_pkg::OP_SEND) begin
        // null check takes precedence over the room checks
        priority if (s1_item_r.msg_id == '0) begin
          res.status = apmq_pkg::ST_NULL_MSG;
        end else if (s1_item_r.kind == apmq_pkg::KIND_ALARM) begin
          if (alarm_valid_r) begin
            res.status = apmq_pkg::ST_NO_ROOM;
          end else begin
            alarm_valid_nxt = 1'b1;
            alarm_id_nxt    = s1_item_r.msg_id;
          end
        end else if (cnt_r == CW'(DEPTH)) begin
          res.status = apmq_pkg::ST_NO_ROOM;
        end else begin
          wr_en      = 1'b1;
          wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
        end
      end else begin
        priority if (alarm_valid_r) begin
          res.out_kind    = apmq_pkg::KIND_ALARM;
          res.out_id      = alarm_id_r;
          alarm_valid_nxt = 1'b0;
          alarm_id_nxt    = '0;
        end else if (cnt_r != '0) begin
          res.out_id = head_data;
          rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
          cnt_nxt    = cnt_r - 1'b1;
        end else begin
          res.status = apmq_pkg::ST_NO_MSG;
        end
      end
    end
    total_sum       = SW'(cnt_nxt) + SW'(alarm_valid_nxt);
    res.total_count = total_sum[apmq_pkg::TOTAL_W-1:0];
    res.alarm_count = alarm_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_valid_r <= 1'b0;
      alarm_id_r    <= '0;
      rd_ptr_r      <= '0;
      wr_ptr_r      <= '0;
      cnt_r         <= '0;
    end else begin
      alarm_valid_r <= alarm_valid_nxt;
      alarm_id_r    <= alarm_id_nxt;
      rd_ptr_r      <= rd_ptr_nxt;
      wr_ptr_r      <= wr_ptr_nxt;
      cnt_r         <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  apmq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk         (clk),
    .wr_en       (wr_en),
    .wr_addr     (wr_ptr_r),
    .wr_data     (s1_item_r.msg_id),
    .rd_addr_nxt (rd_ptr_nxt),
    .head_data   (head_data)
  );

endmodule

>>> hdl/apmq_checker.sv
// Port-level checker for the alarm priority message queue, with its bind.
module apmq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input apmq_pkg::apmq_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input apmq_pkg::apmq_out_t out_data
);

  logic in_txn;
  assign in_txn = in_valid && in_ready && (in_data.operation == apmq_pkg::OP_RECV
                  || in_data.operation == apmq_pkg::OP_SEND);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset leaves nothing in flight, whatever was accepted before
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented right after reset");

  // a delivered alarm empties the alarm slot
  a_alarm_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind == apmq_pkg::KIND_ALARM
    |-> out_data.alarm_count == 1'b0 && out_data.status == apmq_pkg::ST_OK)
    else $error("alarm delivered but slot still counted");

  // an empty receive only happens with nothing held
  a_empty_recv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == apmq_pkg::ST_NO_MSG
    |-> out_data.total_count == '0 && out_data.out_id == '0)
    else $error("empty receive with messages held");

  // an item accepted into an idle block shows on the result port after it
  // has passed the input register and then the result register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_txn && !out_valid ##1 !out_valid |-> ##1 out_valid)
    else $error("result missing after accepted transaction");

endmodule

bind alarm_priority_message_queue_top apmq_checker u_apmq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
